### hdl/rsi_pkg.sv
package rsi_pkg;

  // Field widths of the request and result ports.
  localparam int COORD_W = 32;
  localparam int DIR_W   = 18;
  localparam int RAD_W   = 31;
  localparam int DIST_W  = 31;

  // Default number of fraction bits of the coordinates.
  localparam int FRAC_BITS_DEF = 16;

  // Internal widths that follow from the fixed port widths.
  localparam int L_W    = COORD_W + 1;        // center - origin
  localparam int LMAG_W = COORD_W;            // |L| is below 2^32
  localparam int PROD_W = L_W + DIR_W;        // L * dir
  localparam int TCAW_W = PROD_W + 2;         // sum of three products
  localparam int LSQ_W  = 2 * LMAG_W;         // L_i^2
  localparam int LL_W   = LSQ_W + 2;          // L.L
  localparam int R2_W   = 2 * RAD_W;          // r^2

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  // Handshake and status bits that travel with each request.
  typedef struct packed {
    logic valid;
    logic miss;
  } rsi_ctl_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

  // Width of tca after the fraction bits are dropped.
  function automatic int tca_width(input int frac);
    return TCAW_W - frac;
  endfunction

  // Width of the signed value r^2 + tca^2 - L.L.
  function automatic int h_width(input int frac);
    return max_int(2 * tca_width(frac), LL_W + 1) + 1;
  endfunction

  // Number of root bits, one per square root cell.
  function automatic int sqrt_width(input int frac);
    return h_width(frac) >> 1;
  endfunction

endpackage

### hdl/rsi_front.sv
module rsi_front import rsi_pkg::*; #(
  parameter int  FRAC_BITS = FRAC_BITS_DEF,
  localparam int TcaW      = tca_width(FRAC_BITS),
  localparam int SqW       = sqrt_width(FRAC_BITS),
  localparam int RadW      = 2 * SqW
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      valid_i,
  input  logic signed [COORD_W-1:0] origin_x_i,
  input  logic signed [COORD_W-1:0] origin_y_i,
  input  logic signed [COORD_W-1:0] origin_z_i,
  input  logic signed [DIR_W-1:0]   dir_x_i,
  input  logic signed [DIR_W-1:0]   dir_y_i,
  input  logic signed [DIR_W-1:0]   dir_z_i,
  input  logic signed [COORD_W-1:0] center_x_i,
  input  logic signed [COORD_W-1:0] center_y_i,
  input  logic signed [COORD_W-1:0] center_z_i,
  input  logic        [RAD_W-1:0]   radius_i,
  output rsi_ctl_t                  ctl_o,
  output logic        [RadW-1:0]    rad_o,
  output logic signed [TcaW-1:0]    tca_o
);

  localparam int HsW  = h_width(FRAC_BITS);
  localparam int SplK = (TcaW + 1) / 2;
  localparam int SplH = TcaW - SplK;

  logic [5:1] v_q;

  logic signed [COORD_W-1:0] org   [3];
  logic signed [COORD_W-1:0] ctr   [3];
  logic signed [DIR_W-1:0]   dir   [3];

  // Stage 1: L = center - origin.
  logic signed [L_W-1:0]   l_d   [3];
  logic signed [L_W-1:0]   l_q   [3];
  logic signed [DIR_W-1:0] d_q   [3];
  logic        [RAD_W-1:0] r_q;

  // Stage 2: products.
  logic        [LMAG_W-1:0] lmag [3];
  logic signed [PROD_W-1:0] p_d  [3];
  logic signed [PROD_W-1:0] p_q  [3];
  logic        [LSQ_W-1:0]  lsq_d [3];
  logic        [LSQ_W-1:0]  lsq_q [3];
  logic        [R2_W-1:0]   r2_d;
  logic        [R2_W-1:0]   r2_q;

  // Stage 3: tca and L.L.
  logic signed [TCAW_W-1:0] tcaw;
  logic signed [TcaW-1:0]   tca3_d;
  logic signed [TcaW-1:0]   tca3_q;
  logic        [LL_W-1:0]   ll_d;
  logic        [LL_W-1:0]   ll_q;
  logic        [R2_W-1:0]   r2_3_q;

  // Stage 4: partial products of tca^2 and r^2 - L.L.
  logic        [TcaW-1:0]   tmag;
  logic        [2*SplH-1:0] hh_d;
  logic        [2*SplH-1:0] hh_q;
  logic        [TcaW-1:0]   hl_d;
  logic        [TcaW-1:0]   hl_q;
  logic        [2*SplK-1:0] lo_d;
  logic        [2*SplK-1:0] lo_q;
  logic        [LL_W:0]     diff_d;
  logic        [LL_W:0]     diff4_q;
  logic signed [TcaW-1:0]   tca4_q;

  // Stage 5: tca^2.
  logic        [2*TcaW-1:0] tsq_d;
  logic        [2*TcaW-1:0] tsq_q;
  logic        [LL_W:0]     diff5_q;
  logic signed [TcaW-1:0]   tca5_q;

  // Stage 6: h = r^2 + tca^2 - L.L.
  logic signed [HsW-1:0]    h_d;
  rsi_ctl_t                 ctl_q;
  logic        [RadW-1:0]   rad_q;
  logic signed [TcaW-1:0]   tca6_q;

  always_comb begin
    org[0] = origin_x_i;
    org[1] = origin_y_i;
    org[2] = origin_z_i;
    ctr[0] = center_x_i;
    ctr[1] = center_y_i;
    ctr[2] = center_z_i;
    dir[0] = dir_x_i;
    dir[1] = dir_y_i;
    dir[2] = dir_z_i;
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      l_d[i]   = L_W'(ctr[i]) - L_W'(org[i]);
      lmag[i]  = l_q[i][L_W-1] ? LMAG_W'(-l_q[i]) : LMAG_W'(l_q[i]);
      p_d[i]   = PROD_W'(l_q[i]) * PROD_W'(d_q[i]);
      lsq_d[i] = LSQ_W'(lmag[i]) * LSQ_W'(lmag[i]);
    end
    r2_d = R2_W'(r_q) * R2_W'(r_q);
  end

  always_comb begin
    tcaw   = TCAW_W'(p_q[0]) + TCAW_W'(p_q[1]) + TCAW_W'(p_q[2]);
    // The arithmetic shift rounds toward minus infinity.
    tca3_d = TcaW'(tcaw >>> FRAC_BITS);
    ll_d   = LL_W'(lsq_q[0]) + LL_W'(lsq_q[1]) + LL_W'(lsq_q[2]);
  end

  always_comb begin
    tmag   = tca3_q[TcaW-1] ? TcaW'(-tca3_q) : TcaW'(tca3_q);
    hh_d   = (2*SplH)'(tmag[TcaW-1:SplK]) * (2*SplH)'(tmag[TcaW-1:SplK]);
    hl_d   = TcaW'(tmag[TcaW-1:SplK]) * TcaW'(tmag[SplK-1:0]);
    lo_d   = (2*SplK)'(tmag[SplK-1:0]) * (2*SplK)'(tmag[SplK-1:0]);
    diff_d = (LL_W+1)'(r2_3_q) - (LL_W+1)'(ll_q);
  end

  always_comb begin
    tsq_d = ((2*TcaW)'(hh_q) << (2*SplK))
          + ((2*TcaW)'(hl_q) << (SplK+1))
          + (2*TcaW)'(lo_q);
    h_d   = HsW'(signed'(diff5_q)) + signed'(HsW'(tsq_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      ctl_q <= '0;
    end else if (en_i) begin
      v_q       <= {v_q[4:1], valid_i};
      ctl_q     <= '{valid: v_q[5], miss: h_d[HsW-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        l_q[i]   <= l_d[i];
        d_q[i]   <= dir[i];
        p_q[i]   <= p_d[i];
        lsq_q[i] <= lsq_d[i];
      end
      r_q     <= radius_i;
      r2_q    <= r2_d;
      tca3_q  <= tca3_d;
      ll_q    <= ll_d;
      r2_3_q  <= r2_q;
      hh_q    <= hh_d;
      hl_q    <= hl_d;
      lo_q    <= lo_d;
      diff4_q <= diff_d;
      tca4_q  <= tca3_q;
      tsq_q   <= tsq_d;
      diff5_q <= diff4_q;
      tca5_q  <= tca4_q;
      rad_q   <= RadW'(h_d[HsW-2:0]);
      tca6_q  <= tca5_q;
    end
  end

  assign ctl_o = ctl_q;
  assign rad_o = rad_q;
  assign tca_o = tca6_q;

endmodule

### hdl/rsi_sqrt_cell.sv
module rsi_sqrt_cell import rsi_pkg::*; #(
  parameter int  SqW  = 37,
  parameter int  TcaW = 37,
  localparam int RadW = 2 * SqW,
  localparam int RemW = SqW + 2
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  rsi_ctl_t               ctl_i,
  input  logic        [RemW-1:0] rem_i,
  input  logic        [SqW-1:0]  root_i,
  input  logic        [RadW-1:0] rad_i,
  input  logic signed [TcaW-1:0] tca_i,
  output rsi_ctl_t               ctl_o,
  output logic        [RemW-1:0] rem_o,
  output logic        [SqW-1:0]  root_o,
  output logic        [RadW-1:0] rad_o,
  output logic signed [TcaW-1:0] tca_o
);

  logic [RemW-1:0] cur;
  logic [RemW-1:0] trial;
  logic            ge;

  rsi_ctl_t               ctl_q;
  logic        [RemW-1:0] rem_q;
  logic        [SqW-1:0]  root_q;
  logic        [RadW-1:0] rad_q;
  logic signed [TcaW-1:0] tca_q;

  // One restoring step: bring down the next two radicand bits and try
  // the next root bit. The two top remainder bits are always zero here.
  always_comb begin
    cur   = {rem_i[SqW-1:0], rad_i[RadW-1 -: 2]};
    trial = {root_i, 2'b01};
    ge    = (cur >= trial);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (en_i) begin
      ctl_q <= ctl_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= ge ? (cur - trial) : cur;
      root_q <= {root_i[SqW-2:0], ge};
      rad_q  <= {rad_i[RadW-3:0], 2'b00};
      tca_q  <= tca_i;
    end
  end

  assign ctl_o  = ctl_q;
  assign rem_o  = rem_q;
  assign root_o = root_q;
  assign rad_o  = rad_q;
  assign tca_o  = tca_q;

endmodule

### hdl/ray_sphere_intersect_unit.sv
// Ray/sphere intersection unit.
// Request channel: valid_i with stall_o; signed fixed point ray origin, unit
// direction, sphere center and unsigned radius, FRAC_BITS fraction bits.
// Result channel: valid_o with stall_i, carrying hit_o and distance_o, the
// distance to the nearest non-negative root, saturated; zero on a miss.
// One request is taken per cycle while stall_o is low. A request passes the
// six front stages (difference, products, tca, tca^2 partial products, tca^2,
// radicand), then one square root cell per root bit, then the output register;
// there are sqrt_width(FRAC_BITS) cells, 37 at 16 fraction bits.
// The whole pipe advances together. When the output register holds a result
// that the receiver stalls and the last cell also holds a request, the pipe
// freezes and stall_o is raised; empty slots at the end still drain, so new
// requests keep entering while a result waits. Reset empties all stages.
module ray_sphere_intersect_unit import rsi_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      valid_i,
  output logic                      stall_o,
  input  logic signed [COORD_W-1:0] origin_x_i,
  input  logic signed [COORD_W-1:0] origin_y_i,
  input  logic signed [COORD_W-1:0] origin_z_i,
  input  logic signed [DIR_W-1:0]   dir_x_i,
  input  logic signed [DIR_W-1:0]   dir_y_i,
  input  logic signed [DIR_W-1:0]   dir_z_i,
  input  logic signed [COORD_W-1:0] center_x_i,
  input  logic signed [COORD_W-1:0] center_y_i,
  input  logic signed [COORD_W-1:0] center_z_i,
  input  logic        [RAD_W-1:0]   radius_i,
  output logic                      valid_o,
  input  logic                      stall_i,
  output logic                      hit_o,
  output logic        [DIST_W-1:0]  distance_o
);

  localparam int TcaW = tca_width(FRAC_BITS);
  localparam int SqW  = sqrt_width(FRAC_BITS);
  localparam int RadW = 2 * SqW;
  localparam int RemW = SqW + 2;
  localparam int TtW  = max_int(TcaW, SqW + 1) + 1;

  logic en;
  logic take;

  rsi_ctl_t               ctl_c  [SqW+1];
  logic        [RemW-1:0] rem_c  [SqW+1];
  logic        [SqW-1:0]  root_c [SqW+1];
  logic        [RadW-1:0] rad_c  [SqW+1];
  logic signed [TcaW-1:0] tca_c  [SqW+1];

  logic signed [TtW-1:0]  tca_x;
  logic signed [TtW-1:0]  thc_x;
  logic signed [TtW-1:0]  t_near;
  logic signed [TtW-1:0]  t_far;
  logic signed [TtW-1:0]  t_sel;
  logic                   hit_d;
  logic        [DIST_W-1:0] dist_d;

  logic                   out_valid_q;
  logic                   hit_q;
  logic        [DIST_W-1:0] dist_q;

  // The output register can load when it is empty or being read; the pipe
  // can also move when its last slot is empty.
  assign take    = !out_valid_q || !stall_i;
  assign en      = take || !ctl_c[SqW].valid;
  assign stall_o = !en;

  rsi_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (valid_i),
    .origin_x_i(origin_x_i),
    .origin_y_i(origin_y_i),
    .origin_z_i(origin_z_i),
    .dir_x_i   (dir_x_i),
    .dir_y_i   (dir_y_i),
    .dir_z_i   (dir_z_i),
    .center_x_i(center_x_i),
    .center_y_i(center_y_i),
    .center_z_i(center_z_i),
    .radius_i  (radius_i),
    .ctl_o     (ctl_c[0]),
    .rad_o     (rad_c[0]),
    .tca_o     (tca_c[0])
  );

  assign rem_c[0]  = '0;
  assign root_c[0] = '0;

  for (genvar k = 0; k < SqW; k++) begin : g_cell
    rsi_sqrt_cell #(
      .SqW (SqW),
      .TcaW(TcaW)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .en_i  (en),
      .ctl_i (ctl_c[k]),
      .rem_i (rem_c[k]),
      .root_i(root_c[k]),
      .rad_i (rad_c[k]),
      .tca_i (tca_c[k]),
      .ctl_o (ctl_c[k+1]),
      .rem_o (rem_c[k+1]),
      .root_o(root_c[k+1]),
      .rad_o (rad_c[k+1]),
      .tca_o (tca_c[k+1])
    );
  end

  // Pick the near root, fall back to the far one, then saturate.
  always_comb begin
    tca_x  = TtW'(tca_c[SqW]);
    thc_x  = signed'(TtW'(root_c[SqW]));
    t_near = tca_x - thc_x;
    t_far  = tca_x + thc_x;
    t_sel  = t_near[TtW-1] ? t_far : t_near;
    hit_d  = !ctl_c[SqW].miss && !t_sel[TtW-1];
    if (!hit_d) begin
      dist_d = '0;
    end else if (t_sel[TtW-2:DIST_W] != '0) begin
      dist_d = DIST_MAX;
    end else begin
      dist_d = t_sel[DIST_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take) begin
      out_valid_q <= ctl_c[SqW].valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      hit_q  <= hit_d;
      dist_q <= dist_d;
    end
  end

  assign valid_o    = out_valid_q;
  assign hit_o      = hit_q;
  assign distance_o = dist_q;

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !hit_q) |-> (dist_q == '0))
    else $error("miss result carries a nonzero distance");

  a_last_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && ctl_c[SqW].valid) |=> out_valid_q)
    else $error("finished request did not reach the output register");

  a_bubble_flows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!ctl_c[SqW].valid && !out_valid_q) |-> !stall_o)
    else $error("request stalled although the pipe end is empty");

  a_hold_frozen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stall_o && ctl_c[SqW].valid) |=> ctl_c[SqW].valid)
    else $error("request lost from the last cell while frozen");

endmodule
